// ----- rtl/core/bitmap_first_fit_allocator_core_defines.svh -----
// assertion helpers shared by the checker files
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bffa_pkg.sv -----
package bffa_pkg;

	// default map size and field widths
	localparam int MAP_BITS_DEF = 1024;
	localparam int OPCODE_W     = 2;
	localparam int INDEX_W      = 16;
	localparam int STATUS_W     = 2;
	localparam int GRANT_W      = 10;
	localparam int CFG_W        = 4;

	localparam logic [CFG_W-1:0] RESERVED_RESET = 4'd7;

	// request opcodes
	localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STS_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STS_FREE  = 2'd3;

	// bitmap read address select
	typedef enum logic [1:0] {
		RD_ZERO = 2'd0,
		RD_IDX  = 2'd1,
		RD_NEXT = 2'd2
	} rd_sel_t;

	// bitmap write data select
	typedef enum logic [1:0] {
		WR_INIT = 2'd0,
		WR_SET  = 2'd1,
		WR_CLR  = 2'd2
	} wr_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic                load_req;
		logic                rd_en;
		rd_sel_t             rd_sel;
		logic                wr_en;
		wr_sel_t             wr_sel;
		logic                clr_start;
		logic                clr_step;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_grant;
		logic                out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [OPCODE_W-1:0] op;
		logic                range_err;
		logic                word_free;
		logic                word_last;
		logic                bit_set;
		logic                clr_last;
		logic                out_busy;
	} sts_t;

endpackage

// ----- rtl/core/bffa_ctrl.sv -----
module bffa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  bffa_pkg::sts_t sts,
	output bffa_pkg::cmd_t cmd
);
	import bffa_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR    = 6'b000001,
		ST_IDLE     = 6'b000010,
		ST_DISPATCH = 6'b000100,
		ST_SCAN     = 6'b001000,
		ST_FCHK     = 6'b010000,
		ST_RESP     = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   init_rsp_q, init_rsp_d;

	// state register, reset starts the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			init_rsp_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			init_rsp_q <= init_rsp_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		init_rsp_d = init_rsp_q;
		cmd        = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = WR_INIT;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					init_rsp_d = 1'b0;
					state_d    = init_rsp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (sts.op)
					OP_ALLOC: begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_ZERO;
						state_d    = ST_SCAN;
					end
					OP_FREE: begin
						if (sts.range_err) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = STS_RANGE;
							state_d        = ST_RESP;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_IDX;
							state_d    = ST_FCHK;
						end
					end
					OP_INIT: begin
						cmd.clr_start  = 1'b1;
						cmd.res_load   = 1'b1;
						cmd.res_status = STS_OK;
						init_rsp_d     = 1'b1;
						state_d        = ST_CLEAR;
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = STS_OK;
						state_d        = ST_RESP;
					end
				endcase
			end
			ST_SCAN: begin
				if (sts.word_free) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_SET;
					cmd.res_load   = 1'b1;
					cmd.res_status = STS_OK;
					cmd.res_grant  = 1'b1;
					state_d        = ST_RESP;
				end else if (sts.word_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = STS_FULL;
					state_d        = ST_RESP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			ST_FCHK: begin
				cmd.res_load = 1'b1;
				if (sts.bit_set) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_CLR;
					cmd.res_status = STS_OK;
				end else begin
					cmd.res_status = STS_FREE;
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/bffa_dpath.sv -----
module bffa_dpath #(
	parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bffa_pkg::OPCODE_W-1:0]  opcode,
	input  logic [bffa_pkg::INDEX_W-1:0]   entry_index,
	input  logic                           cfg_wr_en,
	input  logic [bffa_pkg::CFG_W-1:0]     cfg_wr_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [bffa_pkg::STATUS_W-1:0]  status,
	output logic [bffa_pkg::GRANT_W-1:0]   granted_index,
	input  bffa_pkg::cmd_t                 cmd,
	output bffa_pkg::sts_t                 sts
);
	import bffa_pkg::*;

	localparam int MAP_WORDS = (MAP_BITS + 7) / 8;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int TAIL      = MAP_BITS % 8;
	localparam logic [7:0] LAST_MASK = (TAIL == 0) ? 8'hFF : 8'((1 << TAIL) - 1);
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	logic [7:0]          mem [MAP_WORDS];
	logic [7:0]          rd_data_q;
	logic [AW-1:0]       rd_addr_q;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [7:0]          wr_data;
	logic [OPCODE_W-1:0] op_q;
	logic [INDEX_W-1:0]  entry_q;
	logic [CFG_W-1:0]    reserved_q;
	logic [CFG_W-1:0]    sweep_n_q;
	logic [AW-1:0]       clr_addr_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [GRANT_W-1:0]  res_granted_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [GRANT_W-1:0]  granted_q;
	logic [7:0]          free_bits;
	logic [2:0]          free_pos;
	logic [AW+2:0]       grant_full;
	logic [31:0]         grant_wide;
	logic [AW-1:0]       idx_word;

	// init pattern for one word: bits below the reserved count, inside the map
	function automatic logic [7:0] init_word(input logic [AW-1:0] w, input logic [CFG_W-1:0] n);
		logic [7:0] v;
		int         idx;
		v = '0;
		for (int b = 0; b < 8; b++) begin
			idx  = int'(w) * 8 + b;
			v[b] = (idx < int'(n)) && (idx < MAP_BITS);
		end
		return v;
	endfunction

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q    <= opcode;
			entry_q <= entry_index;
		end
	end

	// config register and clearing sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= RESERVED_RESET;
			sweep_n_q  <= RESERVED_RESET;
			clr_addr_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				reserved_q <= cfg_wr_data;
			end
			if (cmd.clr_start) begin
				sweep_n_q  <= reserved_q;
				clr_addr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	assign idx_word = entry_q[AW+2:3];

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: rd_addr = '0;
			RD_IDX:  rd_addr = idx_word;
			RD_NEXT: rd_addr = rd_addr_q + AW'(1);
			default: rd_addr = '0;
		endcase
	end

	// lowest free bit of the fetched word
	assign free_bits = ~rd_data_q & ((rd_addr_q == LAST_WORD) ? LAST_MASK : 8'hFF);

	always_comb begin
		free_pos = '0;
		for (int b = 7; b >= 0; b--) begin
			if (free_bits[b]) begin
				free_pos = 3'(b);
			end
		end
	end

	assign grant_full = {rd_addr_q, free_pos};
	assign grant_wide = 32'(grant_full);

	// write address and data select
	always_comb begin
		case (cmd.wr_sel)
			WR_INIT: begin
				wr_addr = clr_addr_q;
				wr_data = init_word(clr_addr_q, sweep_n_q);
			end
			WR_SET: begin
				wr_addr = rd_addr_q;
				wr_data = rd_data_q | (8'd1 << free_pos);
			end
			WR_CLR: begin
				wr_addr = rd_addr_q;
				wr_data = rd_data_q & ~(8'd1 << entry_q[2:0]);
			end
			default: begin
				wr_addr = rd_addr_q;
				wr_data = rd_data_q;
			end
		endcase
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q  <= cmd.res_status;
			res_granted_q <= cmd.res_grant ? grant_wide[GRANT_W-1:0] : '0;
		end
		if (cmd.out_load) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;

	// status back to the controller
	assign sts.op        = op_q;
	assign sts.range_err = 32'(entry_q) >= 32'(MAP_BITS);
	assign sts.word_free = |free_bits;
	assign sts.word_last = (rd_addr_q == LAST_WORD);
	assign sts.bit_set   = rd_data_q[entry_q[2:0]];
	assign sts.clr_last  = (clr_addr_q == LAST_WORD);
	assign sts.out_busy  = out_valid_q && !out_ready;

endmodule

// ----- rtl/core/bitmap_first_fit_allocator_core.sv -----
// Bitmap first-fit allocator: one used/free bit per entry, MAP_BITS entries,
// held as ceil(MAP_BITS/8) bytes in a single-port-write, registered-read memory.
// Request channel (in_valid/in_ready): opcode and entry_index. Opcode 0
// allocates the lowest free entry, 1 frees entry_index, 2 re-initializes the
// map with the lowest reserved_low entries used, 3 does nothing.
// Result channel (out_valid/out_ready): status and granted_index, one result
// per request, in order. reserved_low is written through cfg_wr_en/cfg_wr_data
// and only affects the next init.
// One request is in work at a time. An allocate reads words from word 0 up to
// the first one with a free entry (or the last word, also for a full map); a
// free reads the word of entry_index and checks its bit (no read when out of
// range); an init runs a clearing pass; out_valid and in_ready rise together.
// The allocate scan reads one bitmap word per cycle; init clears one word per
// cycle through the same write port.
// Reset: the map is rebuilt by a clearing pass over every bitmap word, with
// the lowest seven entries used; in_ready stays low meanwhile, configuration
// writes are still taken.
// A stalled receiver holds the result in the output register; the next request
// is still accepted and worked, and its result waits until the register drains.
module bitmap_first_fit_allocator_core #(
	parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bffa_pkg::OPCODE_W-1:0] opcode,
	input  logic [bffa_pkg::INDEX_W-1:0]  entry_index,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bffa_pkg::STATUS_W-1:0] status,
	output logic [bffa_pkg::GRANT_W-1:0]  granted_index,
	input  logic                          cfg_wr_en,
	input  logic [bffa_pkg::CFG_W-1:0]    cfg_wr_data
);
	import bffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	bffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bitmap, scan and result registers
	bffa_dpath #(
		.MAP_BITS (MAP_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (opcode),
		.entry_index   (entry_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.granted_index (granted_index),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ----- rtl/core/bffa_checker.sv -----
`include "bitmap_first_fit_allocator_core_defines.svh"

module bffa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bffa_pkg::STATUS_W-1:0] status,
	input logic [bffa_pkg::GRANT_W-1:0]  granted_index
);
	import bffa_pkg::*;

	// a stalled result stays offered
	`BFFA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid, "result dropped while stalled")

	// a stalled result keeps its payload
	`BFFA_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(status) && $stable(granted_index), "result changed while stalled")

	// only one request in work: ready drops after an accept
	`BFFA_ASSERT_NEXT(a_one_busy, clk, arst_n, in_valid && in_ready,
		!in_ready, "second request taken while busy")

	// only a successful allocate reports an index: a failed request reports zero
	`BFFA_ASSERT_NOW(a_grant_zero, clk, arst_n, out_valid && (status != STS_OK),
		granted_index == '0, "index reported on a failed request")

endmodule

bind bitmap_first_fit_allocator_core bffa_checker u_bffa_checker (.*);

// ----- dv/bitmap_first_fit_allocator_core_tb.sv -----
module bitmap_first_fit_allocator_core_tb;
	import bffa_pkg::*;

	localparam int MAP_BITS     = MAP_BITS_DEF;
	localparam int DRAIN_CYCLES = MAP_BITS / 8 + 8;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int INDEX_MAX    = (1 << INDEX_W) - 1;

	// one expected result of a request
	typedef struct packed {
		logic [STATUS_W-1:0] sts;
		logic [GRANT_W-1:0]  grant;
	} alloc_result_t;

	// shapes of random request sequences
	typedef enum int {
		SEQ_ALLOC_RUN,
		SEQ_FREE_USED,
		SEQ_MIXED,
		SEQ_FREE_FREE,
		SEQ_RANGE,
		SEQ_NOISE,
		SEQ_INIT_NOP
	} seq_kind_t;

	// mirror of the used/free map and the results it implies
	class free_map_tracker;
		bit [MAP_BITS-1:0] used;
		logic [CFG_W-1:0]  reserved;
		alloc_result_t     pending_results[$];
		int                noted;
		int                checked;
		int                mismatches;

		function new();
			reserved   = RESERVED_RESET;
			noted      = 0;
			checked    = 0;
			mismatches = 0;
			rebuild();
		endfunction

		// clear the map and mark the lowest reserved entries used
		function void rebuild();
			int n;
			n = int'(reserved);
			if (n > MAP_BITS)
				n = MAP_BITS;
			used = '0;
			for (int i = 0; i < n; i++)
				used[i] = 1'b1;
		endfunction

		// apply one accepted request to the map and work out its result
		function alloc_result_t predict_request(logic [OPCODE_W-1:0] op,
			logic [INDEX_W-1:0] idx);
			alloc_result_t r;
			r.sts   = STS_OK;
			r.grant = '0;
			case (op)
				OP_ALLOC: begin
					r.sts = STS_FULL;
					for (int i = 0; i < MAP_BITS; i++) begin
						if (!used[i]) begin
							used[i] = 1'b1;
							r.sts   = STS_OK;
							r.grant = GRANT_W'(i);
							break;
						end
					end
				end
				OP_FREE: begin
					if (idx >= MAP_BITS)
						r.sts = STS_RANGE;
					else if (!used[idx])
						r.sts = STS_FREE;
					else
						used[idx] = 1'b0;
				end
				OP_INIT: rebuild();
				default: ;
			endcase
			return r;
		endfunction

		function void note_request(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx);
			pending_results.push_back(predict_request(op, idx));
			noted++;
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [GRANT_W-1:0] gr);
			alloc_result_t exp;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d granted_index %0d", st, gr);
				return;
			end
			exp = pending_results.pop_front();
			if (st !== exp.sts || gr !== exp.grant) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: status exp %0d got %0d, granted_index exp %0d got %0d",
						checked, exp.sts, st, exp.grant, gr);
			end
			checked++;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function int count_free();
			return MAP_BITS - $countones(used);
		endfunction

		// random entry in the wanted state, or -1 if there is none
		function int pick_entry(bit want_used);
			int start;
			int idx;
			start = $urandom_range(0, MAP_BITS - 1);
			for (int k = 0; k < MAP_BITS; k++) begin
				idx = (start + k) % MAP_BITS;
				if (used[idx] == want_used)
					return idx;
			end
			return -1;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode;
	logic [INDEX_W-1:0]  entry_index;
	logic                out_valid;
	logic                out_ready;
	logic [STATUS_W-1:0] status;
	logic [GRANT_W-1:0]  granted_index;
	logic                cfg_wr_en;
	logic [CFG_W-1:0]    cfg_wr_data;

	free_map_tracker tracker = new();
	int burst_left = 0;
	int cycle_count = 0;
	bit long_hold_done = 1'b0;

	bitmap_first_fit_allocator_core #(
		.MAP_BITS(MAP_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.entry_index  (entry_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #4 clk = ~clk;

	// offer one request in bursts with random gaps, note it when taken
	task automatic issue(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		opcode      <= op;
		entry_index <= idx;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.note_request(op, idx);
	endtask

	// stop offering and wait until every result is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_reserved(input logic [CFG_W-1:0] value);
		cfg_wr_data <= value;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		tracker.reserved = value;
		cfg_wr_en <= 1'b0;
	endtask

	// free a used entry, or allocate when nothing is used
	task automatic free_used_entry();
		int u;
		u = tracker.pick_entry(1'b1);
		if (u < 0)
			issue(OP_ALLOC, INDEX_W'($urandom));
		else
			issue(OP_FREE, INDEX_W'(u));
	endtask

	task automatic random_sequence();
		seq_kind_t kind;
		int len;
		int u;
		kind = seq_kind_t'($urandom_range(0, SEQ_INIT_NOP));
		len  = $urandom_range(1, 10);
		case (kind)
			SEQ_ALLOC_RUN: repeat (len) issue(OP_ALLOC, INDEX_W'($urandom));
			SEQ_FREE_USED: repeat (len) free_used_entry();
			SEQ_MIXED: begin
				repeat (len) begin
					if ($urandom_range(0, 1))
						issue(OP_ALLOC, INDEX_W'($urandom));
					else
						free_used_entry();
				end
			end
			SEQ_FREE_FREE: begin
				repeat (len / 3 + 1) begin
					u = tracker.pick_entry(1'b0);
					if (u < 0)
						u = $urandom_range(0, MAP_BITS - 1);
					issue(OP_FREE, INDEX_W'(u));
				end
			end
			SEQ_RANGE: issue(OP_FREE, INDEX_W'($urandom_range(MAP_BITS, INDEX_MAX)));
			SEQ_NOISE: begin
				repeat (len)
					issue(OPCODE_W'($urandom_range(OP_ALLOC, OP_NOP)), INDEX_W'($urandom));
			end
			SEQ_INIT_NOP: begin
				if ($urandom_range(0, 3) == 0)
					issue(OP_INIT, INDEX_W'($urandom));
				else
					issue(OP_NOP, INDEX_W'($urandom));
			end
			default: ;
		endcase
	endtask

	task automatic random_phase(input int count);
		int target;
		target = tracker.noted + count;
		while (tracker.noted < target)
			random_sequence();
	endtask

	// check every result taken on the output channel
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_result(status, granted_index);
	end

	// receiver stall patterns, with one long hold-off to back the block up
	initial begin
		int mode;
		int len;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(20, 200);
			repeat (len) begin
				if (!long_hold_done && tracker.noted >= 150) begin
					long_hold_done = 1'b1;
					out_ready <= 1'b0;
					repeat (600) @(posedge clk);
				end
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** bitmap_first_fit_allocator_core: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_cfg[7];
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_NOP;
		entry_index = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset map: lowest seven used
		issue(OP_ALLOC, 16'hFFFF);
		issue(OP_ALLOC, 16'h0000);
		issue(OP_FREE, 16'd7);
		issue(OP_FREE, 16'd7);
		issue(OP_ALLOC, 16'h5555);
		issue(OP_FREE, 16'd0);
		issue(OP_ALLOC, 16'hAAAA);
		issue(OP_FREE, INDEX_W'(MAP_BITS - 1));
		issue(OP_FREE, INDEX_W'(MAP_BITS));
		issue(OP_FREE, 16'hFFFF);
		issue(OP_FREE, 16'h8000);
		issue(OP_NOP, 16'hFFFF);
		issue(OP_NOP, 16'h0000);
		issue(OP_INIT, 16'h1234);
		issue(OP_ALLOC, 16'h0000);

		// no reserved entries at all
		settle();
		set_reserved(4'd0);
		issue(OP_INIT, 16'hFFFF);
		issue(OP_ALLOC, 16'h0000);
		issue(OP_FREE, 16'd0);
		issue(OP_FREE, 16'd0);

		// register write leaves the map alone until the next init
		settle();
		set_reserved(4'd15);
		issue(OP_ALLOC, 16'h0000);
		issue(OP_INIT, 16'h0000);
		issue(OP_ALLOC, 16'h0000);
		issue(OP_FREE, 16'd14);
		issue(OP_ALLOC, 16'h0000);

		// fill the whole map, then run against a full map
		settle();
		set_reserved(4'd8);
		issue(OP_INIT, 16'h0000);
		while (tracker.count_free() > 0)
			issue(OP_ALLOC, INDEX_W'($urandom));
		repeat (3) issue(OP_ALLOC, INDEX_W'($urandom));
		issue(OP_FREE, INDEX_W'(MAP_BITS - 1));
		issue(OP_ALLOC, 16'h0000);
		repeat (4) free_used_entry();
		repeat (6) issue(OP_ALLOC, INDEX_W'($urandom));
		issue(OP_INIT, 16'h0000);

		// random phases across several reserved counts
		phase_cfg[0] = 4'd1;
		phase_cfg[1] = 4'd0;
		phase_cfg[2] = 4'd15;
		phase_cfg[3] = 4'd8;
		phase_cfg[4] = CFG_W'($urandom_range(0, 15));
		phase_cfg[5] = RESERVED_RESET;
		phase_cfg[6] = CFG_W'($urandom_range(0, 15));
		foreach (phase_cfg[p]) begin
			settle();
			set_reserved(phase_cfg[p]);
			issue(OP_INIT, INDEX_W'($urandom));
			random_phase(8);
		end

		settle();
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** bitmap_first_fit_allocator_core: PASSED **");
		else
			$display("** bitmap_first_fit_allocator_core: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bffa_pkg.sv
rtl/core/bffa_ctrl.sv
rtl/core/bffa_dpath.sv
rtl/core/bitmap_first_fit_allocator_core.sv
rtl/core/bffa_checker.sv
dv/bitmap_first_fit_allocator_core_tb.sv
